FILE: rtl/core/rlts_pkg.sv
// ----------------------------------------------------------------------------
// rlts_pkg
// Shared types and constants for the Rust literal token scanner: scan phases,
// token kinds, code point constants, the character class bundle and the
// per-beat scan result.
// ----------------------------------------------------------------------------
package rlts_pkg;

	// Fixed field widths of the channels
	localparam int unsigned CH_W    = 21;
	localparam int unsigned MASK_W  = 3;
	localparam int unsigned OUT_W   = 16;

	// Number of phase hand-overs that one code point can pass through
	localparam int unsigned SETTLE_STEPS = 4;

	// Allowed-kind mask bits
	localparam int unsigned ALLOW_FLOAT   = 0;
	localparam int unsigned ALLOW_RAW     = 1;
	localparam int unsigned ALLOW_COMMENT = 2;

	// Code points of interest
	localparam logic [CH_W-1:0] CH_NUL   = 21'h00;
	localparam logic [CH_W-1:0] CH_TAB   = 21'h09;
	localparam logic [CH_W-1:0] CH_LF    = 21'h0A;
	localparam logic [CH_W-1:0] CH_FF    = 21'h0C;
	localparam logic [CH_W-1:0] CH_CR    = 21'h0D;
	localparam logic [CH_W-1:0] CH_SPACE = 21'h20;
	localparam logic [CH_W-1:0] CH_QUOTE = 21'h22;
	localparam logic [CH_W-1:0] CH_HASH  = 21'h23;
	localparam logic [CH_W-1:0] CH_STAR  = 21'h2A;
	localparam logic [CH_W-1:0] CH_PLUS  = 21'h2B;
	localparam logic [CH_W-1:0] CH_MINUS = 21'h2D;
	localparam logic [CH_W-1:0] CH_DOT   = 21'h2E;
	localparam logic [CH_W-1:0] CH_SLASH = 21'h2F;
	localparam logic [CH_W-1:0] CH_0     = 21'h30;
	localparam logic [CH_W-1:0] CH_2     = 21'h32;
	localparam logic [CH_W-1:0] CH_3     = 21'h33;
	localparam logic [CH_W-1:0] CH_4     = 21'h34;
	localparam logic [CH_W-1:0] CH_6     = 21'h36;
	localparam logic [CH_W-1:0] CH_9     = 21'h39;
	localparam logic [CH_W-1:0] CH_UP_A  = 21'h41;
	localparam logic [CH_W-1:0] CH_UP_E  = 21'h45;
	localparam logic [CH_W-1:0] CH_UP_Z  = 21'h5A;
	localparam logic [CH_W-1:0] CH_UNDER = 21'h5F;
	localparam logic [CH_W-1:0] CH_LO_A  = 21'h61;
	localparam logic [CH_W-1:0] CH_LO_B  = 21'h62;
	localparam logic [CH_W-1:0] CH_LO_C  = 21'h63;
	localparam logic [CH_W-1:0] CH_LO_E  = 21'h65;
	localparam logic [CH_W-1:0] CH_LO_F  = 21'h66;
	localparam logic [CH_W-1:0] CH_LO_O  = 21'h6F;
	localparam logic [CH_W-1:0] CH_LO_R  = 21'h72;
	localparam logic [CH_W-1:0] CH_LO_X  = 21'h78;
	localparam logic [CH_W-1:0] CH_LO_Z  = 21'h7A;
	localparam logic [CH_W-1:0] CH_ASCII_MAX = 21'h7F;

	typedef enum logic [4:0] {
		PH_IDLE, PH_WS,
		PH_F_START, PH_F_ZERO, PH_F_INT, PH_F_DOT, PH_F_FRAC, PH_F_EXP,
		PH_F_SIGN, PH_F_EXPD0, PH_F_EXPD, PH_F_SFX1, PH_F_SFX2, PH_F_SFX3,
		PH_F_TAIL, PH_F_T1, PH_F_T2,
		PH_RS_START, PH_RS_R, PH_RS_HASH, PH_RS_BODY, PH_RS_CLOSE,
		PH_BC_SLASH, PH_BC_STAR, PH_BC_BODY, PH_BC_ASL, PH_BC_AST
	} phase_t;

	typedef enum logic [1:0] {
		KIND_FLOAT   = 2'd0,
		KIND_RAW     = 2'd1,
		KIND_COMMENT = 2'd2
	} kind_t;

	// Decoded code point
	typedef struct packed {
		logic ws;
		logic dig;
		logic ident;
		logic nul;
		logic zero;
		logic under;
		logic dot;
		logic slash;
		logic star;
		logic hash;
		logic quote;
		logic sign;
		logic ch_b;
		logic ch_c;
		logic ch_r;
		logic ch_e;
		logic ch_f;
		logic ch_x_o;
		logic ch_2;
		logic ch_3;
		logic ch_4;
		logic ch_6;
	} cclass_t;

	// Outcome of one beat through the scanner
	typedef struct packed {
		logic              fin;
		logic              accepted;
		kind_t             kind;
		logic              too_long;
		logic [OUT_W-1:0]  leading_space;
		logic [OUT_W-1:0]  token_length;
	} scan_res_t;

endpackage

FILE: rtl/core/rlts_if.sv
// ----------------------------------------------------------------------------
// rlts_in_if / rlts_out_if
// Valid/ready channels of the scanner: code point beats in, token results out.
// ----------------------------------------------------------------------------
interface rlts_in_if;
	logic                          valid;
	logic                          ready;
	logic                          op;
	logic [rlts_pkg::MASK_W-1:0]   valid_mask;
	logic [rlts_pkg::CH_W-1:0]     ch;

	modport source (output valid, output op, output valid_mask, output ch, input ready);
	modport sink   (input valid, input op, input valid_mask, input ch, output ready);
endinterface

interface rlts_out_if;
	logic                          valid;
	logic                          ready;
	logic                          accepted;
	logic [1:0]                    token_kind;
	logic [rlts_pkg::OUT_W-1:0]    leading_space;
	logic [rlts_pkg::OUT_W-1:0]    token_length;
	logic                          too_long;

	modport source (output valid, output accepted, output token_kind, output leading_space,
		output token_length, output too_long, input ready);
	modport sink   (input valid, input accepted, input token_kind, input leading_space,
		input token_length, input too_long, output ready);
endinterface

FILE: rtl/core/rust_literal_token_scanner.sv
// ----------------------------------------------------------------------------
// rust_literal_token_scanner
// Scans code point beats for a float literal, a raw string or a nested block
// comment, skipping and counting leading whitespace; one result per request.
//
//   channel  | dir | beat payload
//   ---------+-----+------------------------------------------------------
//   items    | in  | op, valid_mask, ch
//   results  | out | accepted, token_kind, leading_space, token_length,
//            |     | too_long
//
// One beat is taken every cycle unless a waiting result stalls the input;
// the scan state machine decides on a code point combinationally, between
// the input register and the result register, which a result passes in turn.
// Reset clears the scan state; the block is idle and ready straight after.
// A waiting result stalls only a beat that would produce another result.
// ----------------------------------------------------------------------------
module rust_literal_token_scanner #(
	parameter int unsigned LENGTH_BITS = 16,
	parameter int unsigned MAX_HASHES  = 255,
	parameter int unsigned DEPTH_BITS  = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	rlts_in_if.sink    items,
	rlts_out_if.source results
);

	rlts_pkg::cclass_t             cc_in;

	// Input register
	logic                          valid_s1;
	logic                          op_s1;
	logic [rlts_pkg::MASK_W-1:0]   mask_s1;
	rlts_pkg::cclass_t             cc_s1;

	// Result register
	logic                          out_valid_q;
	rlts_pkg::scan_res_t           out_q;

	rlts_pkg::scan_res_t           res;
	logic                          advance;

	// Decode the code point ahead of the input register
	rlts_char_class u_class (
		.ch (items.ch),
		.cc (cc_in)
	);

	rlts_scan_fsm #(
		.LENGTH_BITS (LENGTH_BITS),
		.MAX_HASHES  (MAX_HASHES),
		.DEPTH_BITS  (DEPTH_BITS)
	) u_fsm (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.op         (op_s1),
		.valid_mask (mask_s1),
		.cc         (cc_s1),
		.res        (res)
	);

	// Stage 1 moves on unless it has a result and the result register is blocked
	assign advance     = valid_s1 && (!res.fin || !out_valid_q || results.ready);
	assign items.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (items.ready) begin
			valid_s1 <= items.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (items.ready && items.valid) begin
			op_s1   <= items.op;
			mask_s1 <= items.valid_mask;
			cc_s1   <= cc_in;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res.fin) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.fin)
			out_q <= res;
	end

	assign results.valid         = out_valid_q;
	assign results.accepted      = out_q.accepted;
	assign results.token_kind    = out_q.kind;
	assign results.leading_space = out_q.leading_space;
	assign results.token_length  = out_q.token_length;
	assign results.too_long      = out_q.too_long;

endmodule

FILE: rtl/core/rlts_char_class.sv
// ----------------------------------------------------------------------------
// rlts_char_class
// Decodes a 21-bit code point into the class flags the scanner looks at.
// Anything above 127 counts as an identifier character.
// ----------------------------------------------------------------------------
module rlts_char_class (
	input  logic [rlts_pkg::CH_W-1:0] ch,
	output rlts_pkg::cclass_t         cc
);

	logic lower, upper;

	always_comb begin
		lower = (ch >= rlts_pkg::CH_LO_A) && (ch <= rlts_pkg::CH_LO_Z);
		upper = (ch >= rlts_pkg::CH_UP_A) && (ch <= rlts_pkg::CH_UP_Z);

		cc.ws     = (ch == rlts_pkg::CH_SPACE) || (ch == rlts_pkg::CH_TAB) ||
		            (ch == rlts_pkg::CH_LF) || (ch == rlts_pkg::CH_CR) ||
		            (ch == rlts_pkg::CH_FF);
		cc.dig    = (ch >= rlts_pkg::CH_0) && (ch <= rlts_pkg::CH_9);
		cc.under  = (ch == rlts_pkg::CH_UNDER);
		cc.ident  = lower || upper || cc.dig || cc.under || (ch > rlts_pkg::CH_ASCII_MAX);
		cc.nul    = (ch == rlts_pkg::CH_NUL);
		cc.zero   = (ch == rlts_pkg::CH_0);
		cc.dot    = (ch == rlts_pkg::CH_DOT);
		cc.slash  = (ch == rlts_pkg::CH_SLASH);
		cc.star   = (ch == rlts_pkg::CH_STAR);
		cc.hash   = (ch == rlts_pkg::CH_HASH);
		cc.quote  = (ch == rlts_pkg::CH_QUOTE);
		cc.sign   = (ch == rlts_pkg::CH_PLUS) || (ch == rlts_pkg::CH_MINUS);
		cc.ch_b   = (ch == rlts_pkg::CH_LO_B);
		cc.ch_c   = (ch == rlts_pkg::CH_LO_C);
		cc.ch_r   = (ch == rlts_pkg::CH_LO_R);
		cc.ch_e   = (ch == rlts_pkg::CH_LO_E) || (ch == rlts_pkg::CH_UP_E);
		cc.ch_f   = (ch == rlts_pkg::CH_LO_F);
		cc.ch_x_o = (ch == rlts_pkg::CH_LO_X) || (ch == rlts_pkg::CH_LO_O);
		cc.ch_2   = (ch == rlts_pkg::CH_2);
		cc.ch_3   = (ch == rlts_pkg::CH_3);
		cc.ch_4   = (ch == rlts_pkg::CH_4);
		cc.ch_6   = (ch == rlts_pkg::CH_6);
	end

endmodule

FILE: rtl/core/rlts_scan_fsm.sv
// ----------------------------------------------------------------------------
// rlts_scan_fsm
// Scan state machine and counters. Each beat first settles the phase through
// the hand-overs that do not consume the code point, then performs the single
// consuming or deciding action of the settled phase.
// ----------------------------------------------------------------------------
module rlts_scan_fsm #(
	parameter int unsigned LENGTH_BITS = 16,
	parameter int unsigned MAX_HASHES  = 255,
	parameter int unsigned DEPTH_BITS  = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          advance,
	input  logic                          op,
	input  logic [rlts_pkg::MASK_W-1:0]   valid_mask,
	input  rlts_pkg::cclass_t             cc,
	output rlts_pkg::scan_res_t           res
);

	localparam int unsigned HASH_BITS = (MAX_HASHES < 2) ? 1 : $clog2(MAX_HASHES + 1);
	localparam logic [HASH_BITS-1:0] HASH_MAX = HASH_BITS'(MAX_HASHES);

	// State registers
	rlts_pkg::phase_t               phase_q;
	logic [rlts_pkg::MASK_W-1:0]    allowed_q;
	logic [LENGTH_BITS-1:0]         space_q, cons_q, mark_q;
	logic                           fseen_q, sfx_q;
	logic [HASH_BITS-1:0]           fence_q, close_q;
	logic [DEPTH_BITS-1:0]          depth_q;

	// Effective state: a request start clears counters and flags, loads the mask
	rlts_pkg::phase_t               e_phase;
	logic [rlts_pkg::MASK_W-1:0]    e_allowed;
	logic [LENGTH_BITS-1:0]         e_space, e_cons, e_mark;
	logic                           e_fseen, e_sfx;
	logic [HASH_BITS-1:0]           e_fence, e_close;
	logic [DEPTH_BITS-1:0]          e_depth;

	// Settled phase
	rlts_pkg::phase_t               s_phase, s_next;
	logic                           s_fseen;

	// Next state
	rlts_pkg::phase_t               n_phase;
	logic [LENGTH_BITS-1:0]         n_space, n_cons, n_mark;
	logic                           n_fseen, n_sfx;
	logic [HASH_BITS-1:0]           n_fence, n_close;
	logic [DEPTH_BITS-1:0]          n_depth;

	logic [LENGTH_BITS-1:0]         cons_inc, f_len;
	logic [HASH_BITS-1:0]           close_inc;
	logic [DEPTH_BITS-1:0]          depth_dec;
	logic                           do_take, fin, f_acc, f_tl;
	rlts_pkg::kind_t                f_kind;

	// One non-consuming hand-over from a phase, or the phase itself
	function automatic rlts_pkg::phase_t settle_step(
		input rlts_pkg::phase_t             p,
		input rlts_pkg::cclass_t            c,
		input logic [rlts_pkg::MASK_W-1:0]  allowed,
		input logic                         fseen
	);
		rlts_pkg::phase_t r;
		r = p;
		case (p)
			rlts_pkg::PH_WS: begin
				if (!c.ws) begin
					if (allowed[rlts_pkg::ALLOW_COMMENT] && c.slash)
						r = rlts_pkg::PH_BC_SLASH;
					else if (allowed[rlts_pkg::ALLOW_RAW] && (c.ch_r || c.ch_b || c.ch_c))
						r = rlts_pkg::PH_RS_START;
					else if (allowed[rlts_pkg::ALLOW_FLOAT] && c.dig)
						r = rlts_pkg::PH_F_START;
				end
			end
			rlts_pkg::PH_F_START:  if (!c.zero) r = rlts_pkg::PH_F_INT;
			rlts_pkg::PH_F_ZERO:   if (!(c.ch_x_o || c.ch_b)) r = rlts_pkg::PH_F_INT;
			rlts_pkg::PH_F_INT:    if (!(c.dig || c.under || c.dot)) r = rlts_pkg::PH_F_EXP;
			rlts_pkg::PH_F_FRAC:   if (!(c.dig || c.under)) r = rlts_pkg::PH_F_EXP;
			rlts_pkg::PH_F_EXPD:   if (!(c.dig || c.under)) r = rlts_pkg::PH_F_TAIL;
			rlts_pkg::PH_F_DOT:    if (!(c.dig || c.dot || c.ident)) r = rlts_pkg::PH_F_EXP;
			rlts_pkg::PH_F_EXP:    if (!c.ch_e && fseen) r = rlts_pkg::PH_F_TAIL;
			rlts_pkg::PH_F_SIGN:   if (!c.sign) r = rlts_pkg::PH_F_EXPD0;
			rlts_pkg::PH_RS_START: if (!(c.ch_b || c.ch_c)) r = rlts_pkg::PH_RS_R;
			rlts_pkg::PH_RS_CLOSE: if (!c.hash) r = rlts_pkg::PH_RS_BODY;
			rlts_pkg::PH_BC_ASL:   if (!c.star) r = rlts_pkg::PH_BC_BODY;
			rlts_pkg::PH_BC_AST:   if (!c.slash) r = rlts_pkg::PH_BC_BODY;
			default:               r = p;
		endcase
		return r;
	endfunction

	// Start of request
	always_comb begin
		e_phase   = op ? rlts_pkg::PH_WS : phase_q;
		e_allowed = op ? valid_mask : allowed_q;
		e_space   = op ? '0 : space_q;
		e_cons    = op ? '0 : cons_q;
		e_mark    = op ? '0 : mark_q;
		e_fseen   = op ? 1'b0 : fseen_q;
		e_sfx     = op ? 1'b0 : sfx_q;
		e_fence   = op ? '0 : fence_q;
		e_close   = op ? '0 : close_q;
		e_depth   = op ? '0 : depth_q;
	end

	// Settle through non-consuming hand-overs
	always_comb begin
		s_phase = e_phase;
		s_fseen = e_fseen;
		s_next  = e_phase;
		for (int i = 0; i < rlts_pkg::SETTLE_STEPS; i++) begin
			s_next = settle_step(s_phase, cc, e_allowed, s_fseen);
			if (s_phase == rlts_pkg::PH_F_DOT && s_next != rlts_pkg::PH_F_DOT)
				s_fseen = 1'b1;
			s_phase = s_next;
		end
	end

	// Action of the settled phase
	always_comb begin
		cons_inc  = e_cons + 1'b1;
		close_inc = e_close + 1'b1;
		depth_dec = e_depth - 1'b1;

		n_phase = s_phase;
		n_space = e_space;
		n_cons  = e_cons;
		n_mark  = e_mark;
		n_fseen = s_fseen;
		n_sfx   = e_sfx;
		n_fence = e_fence;
		n_close = e_close;
		n_depth = e_depth;
		do_take = 1'b0;
		fin     = 1'b0;
		f_acc   = 1'b0;
		f_kind  = rlts_pkg::KIND_FLOAT;
		f_tl    = 1'b0;
		f_len   = '0;

		case (s_phase)
			rlts_pkg::PH_IDLE: ;
			rlts_pkg::PH_WS: begin
				if (cc.ws) begin
					if (&e_space) begin
						fin  = 1'b1;
						f_tl = 1'b1;
					end else begin
						n_space = e_space + 1'b1;
					end
				end else begin
					fin = 1'b1;
				end
			end

			// float
			rlts_pkg::PH_F_START: begin
				do_take = 1'b1;
				n_phase = rlts_pkg::PH_F_ZERO;
			end
			rlts_pkg::PH_F_ZERO: fin = 1'b1;
			rlts_pkg::PH_F_INT, rlts_pkg::PH_F_FRAC, rlts_pkg::PH_F_EXPD: begin
				do_take = 1'b1;
				if (!(cc.dig || cc.under)) begin
					n_mark  = e_cons;
					n_phase = rlts_pkg::PH_F_DOT;
				end
			end
			rlts_pkg::PH_F_DOT: begin
				if (cc.dig) begin
					do_take = 1'b1;
					n_fseen = 1'b1;
					n_phase = rlts_pkg::PH_F_FRAC;
				end else begin
					fin = 1'b1;
				end
			end
			rlts_pkg::PH_F_EXP: begin
				if (cc.ch_e) begin
					n_mark  = e_cons;
					do_take = 1'b1;
					n_phase = rlts_pkg::PH_F_SIGN;
				end else if (cc.ch_f) begin
					n_mark  = e_cons;
					do_take = 1'b1;
					n_phase = rlts_pkg::PH_F_SFX1;
				end else begin
					fin = 1'b1;
				end
			end
			rlts_pkg::PH_F_SIGN: begin
				do_take = 1'b1;
				n_phase = rlts_pkg::PH_F_EXPD0;
			end
			rlts_pkg::PH_F_EXPD0: begin
				if (cc.dig) begin
					do_take = 1'b1;
					n_fseen = 1'b1;
					n_phase = rlts_pkg::PH_F_EXPD;
				end else begin
					fin   = 1'b1;
					f_acc = s_fseen;
					f_len = s_fseen ? e_mark : '0;
				end
			end
			rlts_pkg::PH_F_SFX1: begin
				if (cc.ch_3 || cc.ch_6) begin
					n_sfx   = cc.ch_6;
					do_take = 1'b1;
					n_phase = rlts_pkg::PH_F_SFX2;
				end else begin
					fin = 1'b1;
				end
			end
			rlts_pkg::PH_F_SFX2: begin
				if ((!e_sfx && cc.ch_2) || (e_sfx && cc.ch_4)) begin
					do_take = 1'b1;
					n_phase = rlts_pkg::PH_F_SFX3;
				end else begin
					fin = 1'b1;
				end
			end
			rlts_pkg::PH_F_SFX3: begin
				fin = 1'b1;
				if (!cc.ident) begin
					f_acc = 1'b1;
					f_len = e_cons;
				end
			end
			rlts_pkg::PH_F_TAIL: begin
				if (cc.ch_f) begin
					do_take = 1'b1;
					n_phase = rlts_pkg::PH_F_T1;
				end else begin
					fin   = 1'b1;
					f_acc = 1'b1;
					f_len = e_cons;
				end
			end
			rlts_pkg::PH_F_T1: begin
				if (cc.ch_3 || cc.ch_6) begin
					do_take = 1'b1;
					n_phase = rlts_pkg::PH_F_T2;
				end else begin
					fin   = 1'b1;
					f_acc = 1'b1;
					f_len = e_cons;
				end
			end
			rlts_pkg::PH_F_T2: begin
				fin   = 1'b1;
				f_acc = 1'b1;
				if (cc.ch_2 || cc.ch_4) begin
					do_take = 1'b1;
					f_len   = cons_inc;
				end else begin
					f_len = e_cons;
				end
			end

			// raw string
			rlts_pkg::PH_RS_START: begin
				do_take = 1'b1;
				n_phase = rlts_pkg::PH_RS_R;
			end
			rlts_pkg::PH_RS_R: begin
				if (cc.ch_r) begin
					do_take = 1'b1;
					n_phase = rlts_pkg::PH_RS_HASH;
				end else begin
					fin = 1'b1;
				end
			end
			rlts_pkg::PH_RS_HASH: begin
				if (cc.hash) begin
					if (e_fence >= HASH_MAX) begin
						fin  = 1'b1;
						f_tl = 1'b1;
					end else begin
						do_take = 1'b1;
						n_fence = e_fence + 1'b1;
					end
				end else if (cc.quote) begin
					do_take = 1'b1;
					n_phase = rlts_pkg::PH_RS_BODY;
				end else begin
					fin = 1'b1;
				end
			end
			rlts_pkg::PH_RS_BODY: begin
				if (cc.nul) begin
					fin = 1'b1;
				end else begin
					do_take = 1'b1;
					if (cc.quote) begin
						n_close = '0;
						if (e_fence == '0) begin
							fin    = 1'b1;
							f_acc  = 1'b1;
							f_kind = rlts_pkg::KIND_RAW;
							f_len  = cons_inc;
						end else begin
							n_phase = rlts_pkg::PH_RS_CLOSE;
						end
					end
				end
			end
			rlts_pkg::PH_RS_CLOSE: begin
				do_take = 1'b1;
				n_close = close_inc;
				if (close_inc >= e_fence) begin
					fin    = 1'b1;
					f_acc  = 1'b1;
					f_kind = rlts_pkg::KIND_RAW;
					f_len  = cons_inc;
				end
			end

			// block comment
			rlts_pkg::PH_BC_SLASH: begin
				do_take = 1'b1;
				n_phase = rlts_pkg::PH_BC_STAR;
			end
			rlts_pkg::PH_BC_STAR: begin
				if (cc.star) begin
					do_take = 1'b1;
					n_depth = DEPTH_BITS'(1);
					n_phase = rlts_pkg::PH_BC_BODY;
				end else begin
					fin = 1'b1;
				end
			end
			rlts_pkg::PH_BC_BODY: begin
				if (cc.nul) begin
					fin = 1'b1;
				end else begin
					do_take = 1'b1;
					if (cc.slash)
						n_phase = rlts_pkg::PH_BC_ASL;
					else if (cc.star)
						n_phase = rlts_pkg::PH_BC_AST;
				end
			end
			rlts_pkg::PH_BC_ASL: begin
				if (&e_depth) begin
					fin  = 1'b1;
					f_tl = 1'b1;
				end else begin
					do_take = 1'b1;
					n_depth = e_depth + 1'b1;
					n_phase = rlts_pkg::PH_BC_BODY;
				end
			end
			rlts_pkg::PH_BC_AST: begin
				do_take = 1'b1;
				n_depth = depth_dec;
				if (depth_dec == '0) begin
					fin    = 1'b1;
					f_acc  = 1'b1;
					f_kind = rlts_pkg::KIND_COMMENT;
					f_len  = cons_inc;
				end else begin
					n_phase = rlts_pkg::PH_BC_BODY;
				end
			end
			default: n_phase = rlts_pkg::PH_IDLE;
		endcase

		// Consuming a code point at the length limit rejects the token
		if (do_take) begin
			if (&e_cons) begin
				fin    = 1'b1;
				f_acc  = 1'b0;
				f_kind = rlts_pkg::KIND_FLOAT;
				f_tl   = 1'b1;
				f_len  = '0;
			end else begin
				n_cons = cons_inc;
			end
		end
		if (fin)
			n_phase = rlts_pkg::PH_IDLE;
	end

	// Result of this beat
	always_comb begin
		res.fin           = fin;
		res.accepted      = f_acc;
		res.kind          = f_acc ? f_kind : rlts_pkg::KIND_FLOAT;
		res.too_long      = f_tl;
		res.leading_space = rlts_pkg::OUT_W'(e_space);
		res.token_length  = f_acc ? rlts_pkg::OUT_W'(f_len) : '0;
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= rlts_pkg::PH_IDLE;
			allowed_q <= '0;
			space_q   <= '0;
			cons_q    <= '0;
			mark_q    <= '0;
			fseen_q   <= 1'b0;
			sfx_q     <= 1'b0;
			fence_q   <= '0;
			close_q   <= '0;
			depth_q   <= '0;
		end else if (advance) begin
			phase_q   <= n_phase;
			allowed_q <= e_allowed;
			space_q   <= n_space;
			cons_q    <= n_cons;
			mark_q    <= n_mark;
			fseen_q   <= n_fseen;
			sfx_q     <= n_sfx;
			fence_q   <= n_fence;
			close_q   <= n_close;
			depth_q   <= n_depth;
		end
	end

endmodule

FILE: rtl/core/rlts_checker.sv
// ----------------------------------------------------------------------------
// rlts_checker
// Port-level checks on the scanner's result channel, bound to the top level.
// ----------------------------------------------------------------------------
module rlts_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        res_valid,
	input logic                        res_ready,
	input logic                        accepted,
	input logic [1:0]                  token_kind,
	input logic [rlts_pkg::OUT_W-1:0]  leading_space,
	input logic [rlts_pkg::OUT_W-1:0]  token_length,
	input logic                        too_long
);

	// A stalled result stays offered
	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result beat withdrawn while stalled");

	// A stalled result keeps its payload
	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(accepted) && $stable(token_kind) &&
			$stable(leading_space) && $stable(token_length) && $stable(too_long))
		else $error("result payload changed while stalled");

	// A rejected request carries no kind and no length
	a_reject_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !accepted |-> token_kind == 2'd0 && token_length == '0)
		else $error("rejected result with kind or length set");

	// A limit hit is always a rejection
	a_too_long_rejects: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && too_long |-> !accepted)
		else $error("too_long set on an accepted token");

endmodule

bind rust_literal_token_scanner rlts_checker u_rlts_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.res_valid     (results.valid),
	.res_ready     (results.ready),
	.accepted      (results.accepted),
	.token_kind    (results.token_kind),
	.leading_space (results.leading_space),
	.token_length  (results.token_length),
	.too_long      (results.too_long)
);
